### src/aabb_pkg.sv
// Shared types, constants and op codes of the bounding-box transform accumulator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package aabb_pkg;

   localparam int COORD_WIDTH        = 32;
   localparam int FRAC_BITS_DEFAULT  = 16;
   localparam int OP_WIDTH           = 3;
   localparam int CSR_COUNT          = 8;
   localparam int CSR_INDEX_WIDTH    = 3;
   localparam int CSR_DATA_WIDTH     = 64;
   localparam int ROW_COUNT          = 4;
   localparam int AXIS_COUNT         = 3;
   localparam int PROD_WIDTH         = 2 * COORD_WIDTH;
   localparam int SUM_WIDTH          = 2 * COORD_WIDTH + 3;
   localparam int W_TOL_LSB          = 1;

   localparam logic [OP_WIDTH-1:0] OP_POINT = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_BOX   = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_XFORM = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_CLEAR = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_GUARD = 3'd4;

   // Identity matrix, two Q16.16 elements per word, lower column in the low half.
   localparam logic [CSR_COUNT-1:0][CSR_DATA_WIDTH-1:0] CSR_RESET = {
      64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000
   };

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
      coord_type           min_x;
      coord_type           min_y;
      coord_type           min_z;
      coord_type           max_x;
      coord_type           max_y;
      coord_type           max_z;
   } req_type;

   typedef struct packed {
      logic      accepted;
      logic      present;
      logic      has_extent;
      coord_type out_min_x;
      coord_type out_min_y;
      coord_type out_min_z;
      coord_type out_max_x;
      coord_type out_max_y;
      coord_type out_max_z;
   } rsp_type;

   // Rounded row results over all eight corners: lowest and highest per row.
   typedef struct packed {
      logic [ROW_COUNT-1:0][SUM_WIDTH-1:0] lo;
      logic [ROW_COUNT-1:0][SUM_WIDTH-1:0] hi;
   } xform_type;

endpackage

`default_nettype wire

### src/aabb_transform_accumulator_core.sv
// Top level of the bounding-box transform accumulator: pipeline, state, config.
// Depends on aabb_pkg and aabb_xform.
//
// Usage:
//  - req channel carries one operation per transaction (point, box, transformed
//    box, clear, guard box); rsp channel returns exactly one result each.
//  - A transaction moves when valid is high and stall is low.
//  - csr port writes one 64-bit matrix word per cycle at csr_index; write
//    only while the block is idle.
//  - A request passes in order through the input register, the products, the
//    row sums and then the merge into the result register, from which the
//    receiver takes it.
//  - Throughput: one transaction per cycle unless stalled; the running box is
//    read and written in the last stage only, so back-to-back merges see each other.
//  - When the receiver stalls with a result pending, the whole pipeline
//    holds and req_stall is raised; nothing is dropped or repeated.
//  - Reset clears the box to empty, the matrix to identity and all valid
//    bits; no clearing pass is needed.
`default_nettype none

module aabb_transform_accumulator_core #(
   parameter int FRAC_BITS = aabb_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  aabb_pkg::req_type                      req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output aabb_pkg::rsp_type                      rsp_payload,
   input  logic                                   csr_write,
   input  logic [aabb_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [aabb_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import aabb_pkg::*;

   localparam int CW        = COORD_WIDTH;
   localparam int DIV_SHIFT = CW + 10;
   localparam int RECIP_W   = CW + 1;
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd999) / 64'd1000);
   localparam logic [CW-1:0] GUARD_MIN = CW'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [CW-1:0] GUARD_BIAS = CW'(500);
   localparam sum_type CMAX   = (sum_type'(1) <<< (CW - 1)) - sum_type'(1);
   localparam sum_type CMIN   = -CMAX - sum_type'(1);
   localparam sum_type W_ONE  = sum_type'(1) <<< FRAC_BITS;
   localparam sum_type W_TOL  = sum_type'(W_TOL_LSB);

   // Configuration words
   logic [CSR_COUNT-1:0][CSR_DATA_WIDTH-1:0] cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CSR_RESET;
      end else if (csr_write) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   // Pipeline control: hold everything while a result waits on a stalled receiver.
   logic advance;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   req_type s1_ff, s2_ff, s3_ff;
   rsp_type rsp_ff, rsp_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff  <= req_payload;
         s2_ff  <= s1_ff;
         s3_ff  <= s2_ff;
         rsp_ff <= rsp_in;
      end
   end

   // Matrix products and rounded row extremes (stages 2 and 3)
   xform_type rows;

   aabb_xform #(
      .FRAC_BITS(FRAC_BITS)
   ) u_xform (
      .clock  (clock),
      .advance(advance),
      .matrix (cfg_ff),
      .item   (s1_ff),
      .rows   (rows)
   );

   // Guard size: largest magnitude in stage 1, divide by 1000 via reciprocal in stage 2.
   logic [CW-1:0] mag_in, mag_ff, quot_ff;
   logic [CW+RECIP_W-1:0] quot_prod;

   always_comb begin
      logic [CW-1:0] m;
      coord_type v [6];
      v[0] = s1_ff.min_x;
      v[1] = s1_ff.min_y;
      v[2] = s1_ff.min_z;
      v[3] = s1_ff.max_x;
      v[4] = s1_ff.max_y;
      v[5] = s1_ff.max_z;
      m = '0;
      for (int i = 0; i < 6; i++) begin
         if (((v[i] < 0) ? -v[i] : v[i]) > m) begin
            m = (v[i] < 0) ? -v[i] : v[i];
         end
      end
      mag_in = m + GUARD_BIAS;
   end

   assign quot_prod = (CW + RECIP_W)'(mag_ff) * (CW + RECIP_W)'(DIV_RECIP);

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff  <= mag_in;
         quot_ff <= CW'(quot_prod >> DIV_SHIFT);
      end
   end

   // Running box
   logic      box_present_ff, box_present_in;
   coord_type box_min_ff [AXIS_COUNT];
   coord_type box_max_ff [AXIS_COUNT];
   coord_type box_min_in [AXIS_COUNT];
   coord_type box_max_in [AXIS_COUNT];

   // Final stage: checks, merge, result selection
   always_comb begin
      coord_type     mn [AXIS_COUNT];
      coord_type     mx [AXIS_COUNT];
      coord_type     cmn [AXIS_COUNT];
      coord_type     cmx [AXIS_COUNT];
      coord_type     rmn [AXIS_COUNT];
      coord_type     rmx [AXIS_COUNT];
      logic [CW:0]   gmn, gmx;
      logic [CW-1:0] guard;
      logic          box_ok, xform_ok, guard_ok, do_merge, ok, pres, ext;
      sum_type       tl, th;

      mn[0] = s3_ff.min_x;
      mn[1] = s3_ff.min_y;
      mn[2] = s3_ff.min_z;
      mx[0] = s3_ff.max_x;
      mx[1] = s3_ff.max_y;
      mx[2] = s3_ff.max_z;

      box_ok = 1'b1;
      for (int a = 0; a < AXIS_COUNT; a++) begin
         if (mn[a] > mx[a]) begin
            box_ok = 1'b0;
         end
      end

      // Transformed box: every corner in range and with w near one.
      xform_ok = box_ok;
      for (int a = 0; a < AXIS_COUNT; a++) begin
         tl = $signed(rows.lo[a]);
         th = $signed(rows.hi[a]);
         if (tl < CMIN || th > CMAX) begin
            xform_ok = 1'b0;
         end
      end
      tl = $signed(rows.lo[3]);
      th = $signed(rows.hi[3]);
      if (tl < W_ONE - W_TOL || th > W_ONE + W_TOL) begin
         xform_ok = 1'b0;
      end

      guard = (quot_ff > GUARD_MIN) ? quot_ff : GUARD_MIN;
      guard_ok = box_ok;
      for (int a = 0; a < AXIS_COUNT; a++) begin
         gmn = (CW + 1)'(mn[a]) - (CW + 1)'(guard);
         gmx = (CW + 1)'(mx[a]) + (CW + 1)'(guard);
         if (gmn[CW] != gmn[CW-1] || gmx[CW] != gmx[CW-1]) begin
            guard_ok = 1'b0;
         end
         rmn[a] = CW'(gmn);
         rmx[a] = CW'(gmx);
      end

      for (int a = 0; a < AXIS_COUNT; a++) begin
         cmn[a] = mn[a];
         cmx[a] = mx[a];
      end
      do_merge = 1'b0;
      ok       = 1'b0;
      unique case (s3_ff.op)
         OP_POINT: begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
               cmx[a] = mn[a];
            end
            do_merge = 1'b1;
            ok       = 1'b1;
         end
         OP_BOX: begin
            do_merge = box_ok;
            ok       = box_ok;
         end
         OP_XFORM: begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
               cmn[a] = CW'(rows.lo[a]);
               cmx[a] = CW'(rows.hi[a]);
            end
            do_merge = xform_ok;
            ok       = xform_ok;
         end
         OP_CLEAR: ok = 1'b1;
         OP_GUARD: ok = guard_ok;
         default:  ok = 1'b0;
      endcase

      box_present_in = box_present_ff;
      for (int a = 0; a < AXIS_COUNT; a++) begin
         box_min_in[a] = box_min_ff[a];
         box_max_in[a] = box_max_ff[a];
      end
      if (s3_ff.op == OP_CLEAR) begin
         box_present_in = 1'b0;
         for (int a = 0; a < AXIS_COUNT; a++) begin
            box_min_in[a] = '0;
            box_max_in[a] = '0;
         end
      end else if (do_merge) begin
         box_present_in = 1'b1;
         for (int a = 0; a < AXIS_COUNT; a++) begin
            if (!box_present_ff || cmn[a] < box_min_ff[a]) begin
               box_min_in[a] = cmn[a];
            end
            if (!box_present_ff || cmx[a] > box_max_ff[a]) begin
               box_max_in[a] = cmx[a];
            end
         end
      end

      if (s3_ff.op == OP_GUARD) begin
         pres = guard_ok;
         if (!guard_ok) begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
               rmn[a] = '0;
               rmx[a] = '0;
            end
         end
      end else begin
         pres = box_present_in;
         for (int a = 0; a < AXIS_COUNT; a++) begin
            rmn[a] = box_min_in[a];
            rmx[a] = box_max_in[a];
         end
      end

      ext = 1'b0;
      for (int a = 0; a < AXIS_COUNT; a++) begin
         if (rmn[a] < rmx[a]) begin
            ext = pres;
         end
      end

      rsp_in.accepted   = ok;
      rsp_in.present    = pres;
      rsp_in.has_extent = ext;
      rsp_in.out_min_x  = rmn[0];
      rsp_in.out_min_y  = rmn[1];
      rsp_in.out_min_z  = rmn[2];
      rsp_in.out_max_x  = rmx[0];
      rsp_in.out_max_y  = rmx[1];
      rsp_in.out_max_z  = rmx[2];
   end

   // Commit the box only when the transaction moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         box_present_ff <= 1'b0;
         for (int a = 0; a < AXIS_COUNT; a++) begin
            box_min_ff[a] <= '0;
            box_max_ff[a] <= '0;
         end
      end else if (advance && s3_valid_ff) begin
         box_present_ff <= box_present_in;
         for (int a = 0; a < AXIS_COUNT; a++) begin
            box_min_ff[a] <= box_min_in[a];
            box_max_ff[a] <= box_max_in[a];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // An absent box or rejected guard reports all-zero coordinates.
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.present |->
         rsp_ff.out_min_x == 0 && rsp_ff.out_min_y == 0 && rsp_ff.out_min_z == 0 &&
         rsp_ff.out_max_x == 0 && rsp_ff.out_max_y == 0 && rsp_ff.out_max_z == 0)
      else $error("absent box reported with nonzero coordinates");

   a_extent_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.has_extent |-> rsp_ff.present)
      else $error("extent flagged without a present box");

   a_empty_state: assert property (@(posedge clock) disable iff (reset)
      !box_present_ff |-> box_min_ff[0] == 0 && box_max_ff[0] == 0 &&
         box_min_ff[1] == 0 && box_max_ff[1] == 0 &&
         box_min_ff[2] == 0 && box_max_ff[2] == 0)
      else $error("empty box holds nonzero bounds");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

### src/aabb_xform.sv
// Two-stage matrix datapath: per-column products, then rounded row extremes.
// Depends on aabb_pkg.
`default_nettype none

module aabb_xform #(
   parameter int FRAC_BITS = aabb_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                                  clock,
   input  logic                                                  advance,
   input  logic [aabb_pkg::CSR_COUNT-1:0][aabb_pkg::CSR_DATA_WIDTH-1:0] matrix,
   input  aabb_pkg::req_type                                     item,
   output aabb_pkg::xform_type                                   rows
);
   import aabb_pkg::*;

   localparam int HW = COORD_WIDTH;

   coord_type                    mel [ROW_COUNT][ROW_COUNT];
   coord_type                    vmn [AXIS_COUNT];
   coord_type                    vmx [AXIS_COUNT];
   logic signed [PROD_WIDTH-1:0] pmn_ff [ROW_COUNT][AXIS_COUNT];
   logic signed [PROD_WIDTH-1:0] pmx_ff [ROW_COUNT][AXIS_COUNT];
   xform_type                    rows_ff;
   xform_type                    rows_in;

   always_comb begin
      for (int r = 0; r < ROW_COUNT; r++) begin
         for (int c = 0; c < ROW_COUNT; c++) begin
            mel[r][c] = matrix[2 * r + c / 2][HW * (c % 2) +: HW];
         end
      end
   end

   assign vmn[0] = item.min_x;
   assign vmn[1] = item.min_y;
   assign vmn[2] = item.min_z;
   assign vmx[0] = item.max_x;
   assign vmx[1] = item.max_y;
   assign vmx[2] = item.max_z;

   // Each element times both ends of its axis; corners pick from these.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            for (int c = 0; c < AXIS_COUNT; c++) begin
               pmn_ff[r][c] <= PROD_WIDTH'(mel[r][c]) * PROD_WIDTH'(vmn[c]);
               pmx_ff[r][c] <= PROD_WIDTH'(mel[r][c]) * PROD_WIDTH'(vmx[c]);
            end
         end
      end
   end

   // Rounding is monotone, so the corner extremes come from per-column extremes.
   always_comb begin
      sum_type lo;
      sum_type hi;
      sum_type a;
      sum_type b;
      sum_type half;
      half = sum_type'(1) <<< (FRAC_BITS - 1);
      for (int r = 0; r < ROW_COUNT; r++) begin
         lo = sum_type'(mel[r][3]) <<< FRAC_BITS;
         hi = lo;
         for (int c = 0; c < AXIS_COUNT; c++) begin
            a = sum_type'(pmn_ff[r][c]);
            b = sum_type'(pmx_ff[r][c]);
            lo = lo + ((a < b) ? a : b);
            hi = hi + ((a < b) ? b : a);
         end
         rows_in.lo[r] = (lo + half) >>> FRAC_BITS;
         rows_in.hi[r] = (hi + half) >>> FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rows_ff <= rows_in;
      end
   end

   assign rows = rows_ff;

endmodule

`default_nettype wire
